// ===== rtl/core/wfsa_pkg.sv =====
// Shared types and codes of the worst-fit segment allocator.
package wfsa_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_ADEC,
    S_SHUP,
    S_WHI,
    S_WLO,
    S_RDEC,
    S_SHDN,
    S_RESP
  } state_e;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] len;
    logic        free;
  } ent_t;

  typedef struct packed {
    func_e       func;
    logic [15:0] size;
    logic [15:0] off;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] offset;
  } res_t;

  localparam int unsigned EntW = $bits(ent_t);
  localparam logic [15:0] PoolLenReset = 16'd1024;
  localparam logic [1:0]  AddrPoolLen = 2'd0;

endpackage

// ===== rtl/core/wfsa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module wfsa_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wfsa_ctrl.sv =====
// Sequencer that scans, splits, merges and shifts the segment table in memory.
module wfsa_ctrl #(
  parameter int unsigned MAX_SEGMENTS = 32,
  parameter int unsigned IW = $clog2(MAX_SEGMENTS),
  parameter int unsigned CW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           pool_len_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  wfsa_pkg::req_t        req_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output wfsa_pkg::res_t        res_o,
  output logic                  ram_we_o,
  output logic [IW-1:0]         ram_waddr_o,
  output wfsa_pkg::ent_t        ram_wdata_o,
  output logic                  ram_re_o,
  output logic [IW-1:0]         ram_raddr_o,
  input  wfsa_pkg::ent_t        ram_rdata_i
);
  import wfsa_pkg::*;

  state_e        state_q, state_d;
  req_t          req_q, req_d;
  res_t          res_q, res_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] sc_q, sc_d;
  logic [CW-1:0] ri_q, ri_d;
  logic          rv_q, rv_d;
  logic          found_q, found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [15:0]   best_len_q, best_len_d;
  logic [15:0]   best_start_q, best_start_d;
  logic          match_q, match_d;
  ent_t          prev_q, prev_d;
  ent_t          cur_q, cur_d;
  logic [IW-1:0] cur_idx_q, cur_idx_d;
  ent_t          nxt_q, nxt_d;
  logic          nxt_ok_q, nxt_ok_d;
  logic          two_q, two_d;
  logic          issue;
  logic          pf, nf;
  logic [CW-1:0] shift_by;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      count_q <= CW'(1);
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    res_q        <= res_d;
    sc_q         <= sc_d;
    ri_q         <= ri_d;
    found_q      <= found_d;
    best_idx_q   <= best_idx_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    match_q      <= match_d;
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    cur_idx_q    <= cur_idx_d;
    nxt_q        <= nxt_d;
    nxt_ok_q     <= nxt_ok_d;
    two_q        <= two_d;
  end

  assign pf       = (cur_idx_q != '0) && prev_q.free;
  assign nf       = nxt_ok_q && nxt_q.free;
  assign shift_by = two_q ? CW'(2) : CW'(1);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_d        = res_q;
    count_d      = count_q;
    sc_d         = sc_q;
    ri_d         = ri_q;
    rv_d         = 1'b0;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    match_d      = match_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    cur_idx_d    = cur_idx_q;
    nxt_d        = nxt_q;
    nxt_ok_d     = nxt_ok_q;
    two_d        = two_q;
    issue        = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = '0;
    ram_wdata_o  = '0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = '0;
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      S_INIT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '{start: 16'd0, len: pool_len_i, free: 1'b1};
        count_d     = CW'(1);
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d    = req_i;
          sc_d     = '0;
          found_d  = 1'b0;
          match_d  = 1'b0;
          nxt_ok_d = 1'b0;
          if (req_i.func == FUNC_ALLOC && req_i.size == 16'd0) begin
            res_d   = '{status: ST_NOFIT, offset: 16'd0};
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue = (sc_q < count_q) && !match_q;
        if (issue) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = sc_q[IW-1:0];
          sc_d        = sc_q + 1'b1;
          ri_d        = sc_q;
        end
        rv_d = issue;
        if (rv_q) begin
          if (req_q.func == FUNC_ALLOC) begin
            if (ram_rdata_i.free && ram_rdata_i.len >= req_q.size &&
                (!found_q || ram_rdata_i.len >= best_len_q)) begin
              found_d      = 1'b1;
              best_idx_d   = ri_q[IW-1:0];
              best_len_d   = ram_rdata_i.len;
              best_start_d = ram_rdata_i.start;
            end
          end else if (match_q) begin
            nxt_d    = ram_rdata_i;
            nxt_ok_d = 1'b1;
            state_d  = S_RDEC;
          end else if (ram_rdata_i.start == req_q.off) begin
            match_d   = 1'b1;
            cur_d     = ram_rdata_i;
            cur_idx_d = ri_q[IW-1:0];
            if (ri_q + 1'b1 >= count_q) begin
              state_d = S_RDEC;
            end
          end else begin
            prev_d = ram_rdata_i;
          end
        end else if (!issue && !match_q) begin
          if (req_q.func == FUNC_ALLOC) begin
            state_d = S_ADEC;
          end else begin
            res_d   = '{status: ST_NOTFOUND, offset: 16'd0};
            state_d = S_RESP;
          end
        end
      end
      S_ADEC: begin
        if (!found_q) begin
          res_d   = '{status: ST_NOFIT, offset: 16'd0};
          state_d = S_RESP;
        end else if (best_len_q == req_q.size) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = best_idx_q;
          ram_wdata_o = '{start: best_start_q, len: best_len_q, free: 1'b0};
          res_d       = '{status: ST_OK, offset: best_start_q};
          state_d     = S_RESP;
        end else if (count_q == CW'(MAX_SEGMENTS)) begin
          res_d   = '{status: ST_FULL, offset: 16'd0};
          state_d = S_RESP;
        end else begin
          sc_d    = count_q - 1'b1;
          state_d = S_SHUP;
        end
      end
      S_SHUP: begin
        issue = sc_q > CW'(best_idx_q);
        if (issue) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = sc_q[IW-1:0];
          sc_d        = sc_q - 1'b1;
          ri_d        = sc_q;
        end
        rv_d = issue;
        if (rv_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = ri_q[IW-1:0] + 1'b1;
          ram_wdata_o = ram_rdata_i;
        end else if (!issue) begin
          state_d = S_WHI;
        end
      end
      S_WHI: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = best_idx_q + 1'b1;
        ram_wdata_o = '{start: best_start_q + req_q.size,
                        len: best_len_q - req_q.size, free: 1'b1};
        state_d     = S_WLO;
      end
      S_WLO: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = best_idx_q;
        ram_wdata_o = '{start: best_start_q, len: req_q.size, free: 1'b0};
        count_d     = count_q + 1'b1;
        res_d       = '{status: ST_OK, offset: best_start_q};
        state_d     = S_RESP;
      end
      S_RDEC: begin
        ram_we_o = !cur_q.free;
        if (cur_q.free) begin
          res_d   = '{status: ST_NOTFOUND, offset: 16'd0};
          state_d = S_RESP;
        end else if (pf && nf) begin
          ram_waddr_o = cur_idx_q - 1'b1;
          ram_wdata_o = '{start: prev_q.start,
                          len: prev_q.len + cur_q.len + nxt_q.len, free: 1'b1};
          two_d       = 1'b1;
          sc_d        = CW'(cur_idx_q) + CW'(2);
          state_d     = S_SHDN;
        end else if (pf) begin
          ram_waddr_o = cur_idx_q - 1'b1;
          ram_wdata_o = '{start: prev_q.start, len: prev_q.len + cur_q.len, free: 1'b1};
          two_d       = 1'b0;
          sc_d        = CW'(cur_idx_q) + CW'(1);
          state_d     = S_SHDN;
        end else if (nf) begin
          ram_waddr_o = cur_idx_q;
          ram_wdata_o = '{start: cur_q.start, len: cur_q.len + nxt_q.len, free: 1'b1};
          two_d       = 1'b0;
          sc_d        = CW'(cur_idx_q) + CW'(2);
          state_d     = S_SHDN;
        end else begin
          ram_waddr_o = cur_idx_q;
          ram_wdata_o = '{start: cur_q.start, len: cur_q.len, free: 1'b1};
          res_d       = '{status: ST_OK, offset: 16'd0};
          state_d     = S_RESP;
        end
      end
      S_SHDN: begin
        issue = sc_q < count_q;
        if (issue) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = sc_q[IW-1:0];
          sc_d        = sc_q + 1'b1;
          ri_d        = sc_q;
        end
        rv_d = issue;
        if (rv_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = IW'(ri_q - shift_by);
          ram_wdata_o = ram_rdata_i;
        end else if (!issue) begin
          count_d = count_q - shift_by;
          res_d   = '{status: ST_OK, offset: 16'd0};
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    if (cfg_we_i) begin
      state_d = S_INIT;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/worst_fit_segment_allocator.sv =====
// Top level of the worst-fit segment allocator: register port, streams and table memory.
//
//  Channel   Direction  Carries
//  s_axis    in         tuser: func; tdata: request_size, release_offset
//  m_axis    out        tdata: granted_offset, status
//  apb       in/out     pool_length at byte address 0
//
// One transaction at a time; the next request is taken only after the result is handed on.
// An allocate scans every segment and, when it splits one, shifts the entries above it up
// by one; a release scans up to the entry after the released one and, when it merges, shifts
// the entries above it down. A rejected request answers without shifting any entries.
// After reset or a pool_length write the table is set up again as one free segment.
// A result waits in the output register while m_axis_tready is low.
module worst_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_size, release_offset
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // granted_offset, status
);
  import wfsa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  logic [15:0]   pool_len_q, pool_len_d;
  logic          cfg_we;
  logic          out_v_q, out_v_d;
  res_t          out_q, out_d;
  req_t          req;
  res_t          res;
  logic          res_valid, res_ready;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  ent_t          ram_wdata, ram_rdata;

  assign pready = 1'b1;
  assign prdata = {16'd0, pool_len_q};
  assign cfg_we = psel && penable && pwrite && (paddr == AddrPoolLen);
  assign pool_len_d = cfg_we ? pwdata[15:0] : pool_len_q;

  assign req = '{func: func_e'(s_axis_tuser), size: s_axis_tdata[15:0],
                 off: s_axis_tdata[31:16]};

  assign res_ready = !out_v_q || m_axis_tready;
  assign out_v_d   = (res_valid && res_ready) || (out_v_q && !m_axis_tready);
  assign out_d     = (res_valid && res_ready) ? res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_len_q <= PoolLenReset;
      out_v_q    <= 1'b0;
    end else begin
      pool_len_q <= pool_len_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.offset};

  wfsa_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .pool_len_i (pool_len_q),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  wfsa_ram #(
    .WIDTH(EntW),
    .DEPTH(MAX_SEGMENTS),
    .AW   (IW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
